/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the access gate controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define AGC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AGC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/agc_pkg.sv */
// ----------------------------------------------------------------------------
// agc_pkg
// Types, codes, member table and helpers for the access gate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package agc_pkg;

	localparam int MEMBER_SLOTS = 8;
	localparam int TIMER_BITS   = 16;
	localparam int DELAY_W      = 16;
	localparam int IR_W         = 10;
	localparam int UID_W        = 32;
	localparam int ID_W         = 8;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 16;
	localparam int CMP_W        = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [ID_W-1:0]       ID_NONE   = {ID_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROMPT_DELAY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PASS_ARM     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_HOLD = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_IR_THRESHOLD = CFG_IDX_W'(3);

	localparam logic [DELAY_W-1:0] RST_PROMPT_DELAY = DELAY_W'(1200);
	localparam logic [DELAY_W-1:0] RST_PASS_ARM     = DELAY_W'(1500);
	localparam logic [DELAY_W-1:0] RST_MESSAGE_HOLD = DELAY_W'(10000);
	localparam logic [IR_W-1:0]    RST_IR_THRESHOLD = IR_W'(450);

	// Screen codes
	localparam logic [2:0] SCR_UNCHANGED = 3'd0;
	localparam logic [2:0] SCR_IDLE      = 3'd1;
	localparam logic [2:0] SCR_WELCOME   = 3'd2;
	localparam logic [2:0] SCR_DENIED    = 3'd3;
	localparam logic [2:0] SCR_PROMPT    = 3'd4;
	localparam logic [2:0] SCR_GATE_OPEN = 3'd5;
	localparam logic [2:0] SCR_ENTRY     = 3'd6;

	// Buzzer codes
	localparam logic [1:0] BUZ_NONE    = 2'd0;
	localparam logic [1:0] BUZ_SUCCESS = 2'd1;
	localparam logic [1:0] BUZ_ERROR   = 2'd2;

	// Access log codes
	localparam logic [1:0] LOG_NONE    = 2'd0;
	localparam logic [1:0] LOG_GRANTED = 2'd1;
	localparam logic [1:0] LOG_DENIED  = 2'd2;

	typedef struct packed {
		logic [DELAY_W-1:0] prompt_delay;
		logic [DELAY_W-1:0] pass_arm;
		logic [DELAY_W-1:0] message_hold;
		logic [IR_W-1:0]    ir_threshold;
	} cfg_t;

	typedef struct packed {
		logic             used;
		logic [UID_W-1:0] uid;
		logic             active;
		logic [ID_W-1:0]  id;
	} member_t;

	// Classified tick, handed from the front end to the back end
	typedef struct packed {
		logic            fall_edge;
		logic            ir_below;
		logic            card;
		logic            card_ok;
		logic [ID_W-1:0] card_id;
	} tick_cls_t;

	typedef struct packed {
		logic [2:0]      screen;
		logic [1:0]      buzzer;
		logic [1:0]      access_log;
		logic [ID_W-1:0] logged_member_id;
		logic            gate_opened_event;
		logic            entry_completed_event;
		logic [ID_W-1:0] session_member_id;
	} result_t;

	// Fixed member list; slots past the list are empty
	function automatic member_t member_at(input int slot);
		member_t m;
		m = '0;
		case (slot)
			0: m = '{1'b1, 32'h3B7D483C, 1'b1, 8'd1};
			1: m = '{1'b1, 32'h3B5CB33C, 1'b1, 8'd2};
			2: m = '{1'b1, 32'h2B40B13C, 1'b1, 8'd3};
			3: m = '{1'b1, 32'h3B15113C, 1'b0, 8'd4};
			4: m = '{1'b1, 32'hCEAECFBD, 1'b1, 8'd5};
			5: m = '{1'b1, 32'h53BEA9FA, 1'b1, 8'd6};
			6: m = '{1'b1, 32'h2545FD00, 1'b1, 8'd7};
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] c);
		return (c == TIMER_MAX) ? c : c + TIMER_BITS'(1);
	endfunction

	function automatic logic timer_reached(input logic [TIMER_BITS-1:0] t,
		input logic [DELAY_W-1:0] d);
		return CMP_W'(t) >= CMP_W'(d);
	endfunction

endpackage

`default_nettype wire

/* rtl/agc_if.sv */
// ----------------------------------------------------------------------------
// agc_if
// Valid/ready channel interfaces: tick input, result output, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface agc_tick_if;
	logic                             valid;
	logic                             ready;
	logic                             button_level;
	logic [agc_pkg::IR_W-1:0]         ir_sample;
	logic                             card_present;
	logic [agc_pkg::UID_W-1:0]        card_uid;
	logic                             uid_is_four_bytes;

	modport source(output valid, output button_level, output ir_sample,
		output card_present, output card_uid, output uid_is_four_bytes, input ready);
	modport sink(input valid, input button_level, input ir_sample,
		input card_present, input card_uid, input uid_is_four_bytes, output ready);
endinterface

interface agc_result_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       screen;
	logic [1:0]                       buzzer;
	logic [1:0]                       access_log;
	logic signed [agc_pkg::ID_W-1:0]  logged_member_id;
	logic                             gate_opened_event;
	logic                             entry_completed_event;
	logic signed [agc_pkg::ID_W-1:0]  session_member_id;

	modport source(output valid, output screen, output buzzer, output access_log,
		output logged_member_id, output gate_opened_event,
		output entry_completed_event, output session_member_id, input ready);
	modport sink(input valid, input screen, input buzzer, input access_log,
		input logged_member_id, input gate_opened_event,
		input entry_completed_event, input session_member_id, output ready);
endinterface

interface agc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [agc_pkg::CFG_IDX_W-1:0]      index;
	logic [agc_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/agc_front.sv */
// ----------------------------------------------------------------------------
// agc_front
// Accepts tick beats, detects the button edge, checks the IR sample and
// looks the card up in the member table, then pushes the classified tick.
// ----------------------------------------------------------------------------
`default_nettype none

module agc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	agc_tick_if.sink                 tick,
	input  logic [agc_pkg::IR_W-1:0] ir_threshold,
	input  logic                     full,
	output logic                     push,
	output agc_pkg::tick_cls_t       push_data
);

	logic                       last_button_q;
	logic                       found;
	logic                       active;
	logic [agc_pkg::ID_W-1:0]   id;
	agc_pkg::member_t           m;

	assign tick.ready = !full;
	assign push       = tick.valid && !full;

	// Walk from the top slot down so the lowest matching slot wins
	always_comb begin
		found  = 1'b0;
		active = 1'b0;
		id     = agc_pkg::ID_NONE;
		m      = '0;
		for (int i = agc_pkg::MEMBER_SLOTS - 1; i >= 0; i--) begin
			m = agc_pkg::member_at(i);
			if (tick.uid_is_four_bytes && m.used && m.uid == tick.card_uid) begin
				found  = 1'b1;
				active = m.active;
				id     = m.id;
			end
		end
	end

	always_comb begin
		push_data.fall_edge = last_button_q && !tick.button_level;
		push_data.ir_below  = tick.ir_sample < ir_threshold;
		push_data.card      = tick.card_present;
		push_data.card_ok   = found && active;
		push_data.card_id   = found ? id : agc_pkg::ID_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_button_q <= 1'b1;
		end else if (push) begin
			last_button_q <= tick.button_level;
		end
	end

endmodule

`default_nettype wire

/* rtl/agc_queue.sv */
// ----------------------------------------------------------------------------
// agc_queue
// Short FIFO of classified ticks between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module agc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  agc_pkg::tick_cls_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               empty,
	output agc_pkg::tick_cls_t head
);

	agc_pkg::tick_cls_t                 entry_q [agc_pkg::QUEUE_DEPTH];
	logic [agc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [agc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [agc_pkg::QUEUE_CNT_W-1:0]    count_q;

	localparam logic [agc_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		agc_pkg::QUEUE_PTR_W'(agc_pkg::QUEUE_DEPTH - 1);
	localparam logic [agc_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		agc_pkg::QUEUE_CNT_W'(agc_pkg::QUEUE_DEPTH);

	assign full  = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`AGC_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_FULL, "queue overfilled")
	`AGC_ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from empty queue")
	`AGC_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !full, "push into full queue")

endmodule

`default_nettype wire

/* rtl/agc_back.sv */
// ----------------------------------------------------------------------------
// agc_back
// Session engine: advances the elapsed-time counters, applies button, IR,
// prompt, timeout and card steps for one tick and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module agc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  agc_pkg::cfg_t      cfg,
	input  logic               empty,
	input  agc_pkg::tick_cls_t head,
	output logic               pop,
	agc_result_if.source       result
);

	logic                               granted_q;
	logic                               pass_logged_q;
	logic                               gate_open_q;
	logic                               prompt_pending_q;
	logic                               status_showing_q;
	logic [agc_pkg::TIMER_BITS-1:0]     since_opened_q;
	logic [agc_pkg::TIMER_BITS-1:0]     since_grant_q;
	logic [agc_pkg::TIMER_BITS-1:0]     since_status_q;
	logic [agc_pkg::ID_W-1:0]           session_id_q;
	logic                               out_valid_q;
	agc_pkg::result_t                   out_q;

	logic                               g_d, pl_d, go_d, pp_d, sh_d;
	logic [agc_pkg::TIMER_BITS-1:0]     so_d, sg_d, ss_d;
	logic [agc_pkg::ID_W-1:0]           sid_d;
	agc_pkg::result_t                   res_d;

	// Take the next tick when the output register is free or being drained
	assign pop = !empty && (!out_valid_q || result.ready);

	always_comb begin
		g_d   = granted_q;
		pl_d  = pass_logged_q;
		go_d  = gate_open_q;
		pp_d  = prompt_pending_q;
		sh_d  = status_showing_q;
		sid_d = session_id_q;
		so_d  = agc_pkg::tick_up(since_opened_q);
		sg_d  = agc_pkg::tick_up(since_grant_q);
		ss_d  = agc_pkg::tick_up(since_status_q);

		res_d                       = '0;
		res_d.screen                = agc_pkg::SCR_UNCHANGED;
		res_d.buzzer                = agc_pkg::BUZ_NONE;
		res_d.access_log            = agc_pkg::LOG_NONE;
		res_d.logged_member_id      = agc_pkg::ID_NONE;

		// Button press: open the gate or drop the session
		if (head.fall_edge) begin
			if (g_d && !go_d) begin
				go_d                    = 1'b1;
				pp_d                    = 1'b0;
				so_d                    = '0;
				res_d.buzzer            = agc_pkg::BUZ_SUCCESS;
				res_d.gate_opened_event = 1'b1;
				res_d.screen            = agc_pkg::SCR_GATE_OPEN;
				ss_d                    = '0;
				sh_d                    = 1'b1;
			end else begin
				g_d          = 1'b0;
				pl_d         = 1'b0;
				go_d         = 1'b0;
				pp_d         = 1'b0;
				sid_d        = agc_pkg::ID_NONE;
				res_d.screen = agc_pkg::SCR_IDLE;
				sh_d         = 1'b0;
			end
		end

		// Person passed the armed sensor
		if (g_d && go_d && !pl_d && head.ir_below &&
			agc_pkg::timer_reached(so_d, cfg.pass_arm)) begin
			res_d.entry_completed_event = 1'b1;
			pl_d                        = 1'b1;
			g_d                         = 1'b0;
			go_d                        = 1'b0;
			res_d.screen                = agc_pkg::SCR_ENTRY;
			ss_d                        = '0;
			sh_d                        = 1'b1;
		end

		if (pp_d && g_d && !go_d && agc_pkg::timer_reached(sg_d, cfg.prompt_delay)) begin
			pp_d         = 1'b0;
			res_d.screen = agc_pkg::SCR_PROMPT;
			ss_d         = '0;
			sh_d         = 1'b1;
		end

		if (sh_d && agc_pkg::timer_reached(ss_d, cfg.message_hold)) begin
			res_d.screen = agc_pkg::SCR_IDLE;
			sh_d         = 1'b0;
		end

		if (head.card) begin
			res_d.screen           = head.card_ok ? agc_pkg::SCR_WELCOME : agc_pkg::SCR_DENIED;
			ss_d                   = '0;
			sh_d                   = 1'b1;
			res_d.logged_member_id = head.card_id;
			go_d                   = 1'b0;
			so_d                   = '0;
			if (head.card_ok) begin
				g_d              = 1'b1;
				pl_d             = 1'b0;
				pp_d             = 1'b1;
				sg_d             = '0;
				sid_d            = head.card_id;
				res_d.buzzer     = agc_pkg::BUZ_SUCCESS;
				res_d.access_log = agc_pkg::LOG_GRANTED;
			end else begin
				g_d              = 1'b0;
				pp_d             = 1'b0;
				res_d.buzzer     = agc_pkg::BUZ_ERROR;
				res_d.access_log = agc_pkg::LOG_DENIED;
			end
		end

		res_d.session_member_id = sid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granted_q        <= 1'b0;
			pass_logged_q    <= 1'b0;
			gate_open_q      <= 1'b0;
			prompt_pending_q <= 1'b0;
			status_showing_q <= 1'b0;
			since_opened_q   <= '0;
			since_grant_q    <= '0;
			since_status_q   <= '0;
			session_id_q     <= agc_pkg::ID_NONE;
			out_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				granted_q        <= g_d;
				pass_logged_q    <= pl_d;
				gate_open_q      <= go_d;
				prompt_pending_q <= pp_d;
				status_showing_q <= sh_d;
				since_opened_q   <= so_d;
				since_grant_q    <= sg_d;
				since_status_q   <= ss_d;
				session_id_q     <= sid_d;
				out_valid_q      <= 1'b1;
			end else if (result.ready) begin
				out_valid_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.screen                = out_q.screen;
	assign result.buzzer                = out_q.buzzer;
	assign result.access_log            = out_q.access_log;
	assign result.logged_member_id      = $signed(out_q.logged_member_id);
	assign result.gate_opened_event     = out_q.gate_opened_event;
	assign result.entry_completed_event = out_q.entry_completed_event;
	assign result.session_member_id     = $signed(out_q.session_member_id);

	`AGC_ASSERT_IMPLIES(a_open_needs_grant, clk, arst_n, gate_open_q, granted_q,
		"gate open without a grant")
	`AGC_ASSERT_IMPLIES(a_prompt_state, clk, arst_n, prompt_pending_q,
		granted_q && !gate_open_q, "prompt pending outside a closed granted session")
	`AGC_ASSERT_IMPLIES(a_logged_closed, clk, arst_n, pass_logged_q, !gate_open_q,
		"gate open after entry logged")

endmodule

`default_nettype wire

/* rtl/access_gate_controller.sv */
// Access gate controller, one tick beat per millisecond.
// Each accepted tick beat is held in the queue, then in the output register.
// Throughput: one tick per cycle while the queue has room; the two-entry queue
// and the output register keep the front end accepting while a result waits.
// Reset (arst_n low): registers at 1200/1500/10000/450, button released,
// session none, all flags and elapsed counters cleared, queue and output empty.
// ----------------------------------------------------------------------------
// access_gate_controller
// Top level: configuration registers, front end, tick queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module access_gate_controller (
	input  logic         clk,
	input  logic         arst_n,
	agc_tick_if.sink     tick,
	agc_result_if.source result,
	agc_cfg_if.sink      cfg
);

	agc_pkg::cfg_t      cfg_q;
	agc_pkg::tick_cls_t push_data;
	agc_pkg::tick_cls_t head;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prompt_delay <= agc_pkg::RST_PROMPT_DELAY;
			cfg_q.pass_arm     <= agc_pkg::RST_PASS_ARM;
			cfg_q.message_hold <= agc_pkg::RST_MESSAGE_HOLD;
			cfg_q.ir_threshold <= agc_pkg::RST_IR_THRESHOLD;
		end else if (cfg.valid) begin
			// Drop writes to unknown indexes
			unique case (cfg.index)
				agc_pkg::REG_PROMPT_DELAY: cfg_q.prompt_delay <= cfg.data;
				agc_pkg::REG_PASS_ARM:     cfg_q.pass_arm     <= cfg.data;
				agc_pkg::REG_MESSAGE_HOLD: cfg_q.message_hold <= cfg.data;
				agc_pkg::REG_IR_THRESHOLD: cfg_q.ir_threshold <= cfg.data[agc_pkg::IR_W-1:0];
				default: ;
			endcase
		end
	end

	agc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.ir_threshold (cfg_q.ir_threshold),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	agc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	agc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

/* sim/access_gate_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_gate_controller_tb
// Drives millisecond tick beats into the gate controller and checks every
// result beat against a cycle-free model of the gate, held in this bench.
// Runs directed card/button/IR cases, card sessions with random content
// under several timing settings, and a long quiet stretch with the gate
// held open. Random stalls are applied on both channels.
// ----------------------------------------------------------------------------

module access_gate_controller_tb;

	localparam logic [agc_pkg::CFG_IDX_W-1:0] REG_SPARE = agc_pkg::CFG_IDX_W'(4);
	localparam logic [agc_pkg::CFG_IDX_W-1:0] REG_TOP   = agc_pkg::CFG_IDX_W'(255);

	// Member list as the gate is expected to know it; slot 7 is empty
	localparam logic [31:0] BADGE_UID [0:7] = '{32'h3B7D483C, 32'h3B5CB33C,
		32'h2B40B13C, 32'h3B15113C, 32'hCEAECFBD, 32'h53BEA9FA, 32'h2545FD00, 32'h0};
	localparam bit BADGE_USED [0:7]   = '{1, 1, 1, 1, 1, 1, 1, 0};
	localparam bit BADGE_ACTIVE [0:7] = '{1, 1, 1, 0, 1, 1, 1, 0};
	localparam logic [7:0] BADGE_ID [0:7] = '{8'd1, 8'd2, 8'd3, 8'd4,
		8'd5, 8'd6, 8'd7, 8'd0};

	typedef struct packed {
		logic        button;
		logic [9:0]  ir;
		logic        card;
		logic [31:0] uid;
		logic        four;
	} gate_tick_t;

	typedef struct packed {
		logic [15:0] prompt;
		logic [15:0] arm;
		logic [15:0] hold;
		logic [9:0]  ir_thr;
	} gate_cfg_t;

	logic clk = 1'b0;
	logic arst_n;

	agc_tick_if   tick_bus();
	agc_result_if result_bus();
	agc_cfg_if    cfg_bus();

	access_gate_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	always #1 clk = ~clk;

	// Gate model state
	gate_cfg_t   cfg_now;
	logic        btn_prev;
	logic        granted_now;
	logic        entry_done;
	logic        gate_is_open;
	logic        prompt_due;
	logic        status_up;
	logic [agc_pkg::TIMER_BITS-1:0] open_age;
	logic [agc_pkg::TIMER_BITS-1:0] grant_age;
	logic [agc_pkg::TIMER_BITS-1:0] status_age;
	logic [7:0]  session_badge;

	gate_tick_t         pending_ticks[$];
	agc_pkg::result_t   gate_outputs_due[$];
	gate_tick_t         on_wire;
	int                 src_gap;
	int                 snk_gap;
	int                 mismatches = 0;
	bit                 bursts_on = 1'b1;

	function automatic logic [agc_pkg::TIMER_BITS-1:0] age_up(
		input logic [agc_pkg::TIMER_BITS-1:0] a);
		return (a == agc_pkg::TIMER_MAX) ? a : a + 1'b1;
	endfunction

	function automatic agc_pkg::result_t advance_gate(input gate_tick_t t);
		agc_pkg::result_t r;
		logic hit;
		logic hit_ok;
		logic [7:0] hit_id;
		int i;
		r = '0;
		r.logged_member_id = agc_pkg::ID_NONE;
		open_age = age_up(open_age);
		grant_age = age_up(grant_age);
		status_age = age_up(status_age);

		if (btn_prev && !t.button) begin
			if (granted_now && !gate_is_open) begin
				gate_is_open = 1'b1;
				prompt_due = 1'b0;
				open_age = '0;
				r.buzzer = agc_pkg::BUZ_SUCCESS;
				r.gate_opened_event = 1'b1;
				r.screen = agc_pkg::SCR_GATE_OPEN;
				status_age = '0;
				status_up = 1'b1;
			end else begin
				granted_now = 1'b0;
				entry_done = 1'b0;
				gate_is_open = 1'b0;
				prompt_due = 1'b0;
				session_badge = agc_pkg::ID_NONE;
				r.screen = agc_pkg::SCR_IDLE;
				status_up = 1'b0;
			end
		end
		btn_prev = t.button;

		if (granted_now && gate_is_open && open_age >= cfg_now.arm && !entry_done &&
			t.ir < cfg_now.ir_thr) begin
			r.entry_completed_event = 1'b1;
			entry_done = 1'b1;
			granted_now = 1'b0;
			gate_is_open = 1'b0;
			r.screen = agc_pkg::SCR_ENTRY;
			status_age = '0;
			status_up = 1'b1;
		end

		if (prompt_due && granted_now && !gate_is_open && grant_age >= cfg_now.prompt) begin
			prompt_due = 1'b0;
			r.screen = agc_pkg::SCR_PROMPT;
			status_age = '0;
			status_up = 1'b1;
		end

		if (status_up && status_age >= cfg_now.hold) begin
			r.screen = agc_pkg::SCR_IDLE;
			status_up = 1'b0;
		end

		if (t.card) begin
			hit = 1'b0;
			hit_ok = 1'b0;
			hit_id = agc_pkg::ID_NONE;
			// only four-byte UIDs can match; lowest slot wins
			if (t.four)
				for (i = 0; i < 8; i++)
					if (!hit && BADGE_USED[i] && BADGE_UID[i] == t.uid) begin
						hit = 1'b1;
						hit_ok = BADGE_ACTIVE[i];
						hit_id = BADGE_ID[i];
					end
			r.screen = hit_ok ? agc_pkg::SCR_WELCOME : agc_pkg::SCR_DENIED;
			status_age = '0;
			status_up = 1'b1;
			r.logged_member_id = hit_id;
			if (hit_ok) begin
				granted_now = 1'b1;
				entry_done = 1'b0;
				gate_is_open = 1'b0;
				open_age = '0;
				prompt_due = 1'b1;
				grant_age = '0;
				session_badge = hit_id;
				r.buzzer = agc_pkg::BUZ_SUCCESS;
				r.access_log = agc_pkg::LOG_GRANTED;
			end else begin
				granted_now = 1'b0;
				gate_is_open = 1'b0;
				open_age = '0;
				prompt_due = 1'b0;
				r.buzzer = agc_pkg::BUZ_ERROR;
				r.access_log = agc_pkg::LOG_DENIED;
			end
		end

		r.session_member_id = session_badge;
		return r;
	endfunction

	function automatic string show(input agc_pkg::result_t r);
		return $sformatf("screen=%0d buzzer=%0d log=%0d logged_id=%0d opened=%0b entry=%0b session=%0d",
			r.screen, r.buzzer, r.access_log, $signed(r.logged_member_id),
			r.gate_opened_event, r.entry_completed_event, $signed(r.session_member_id));
	endfunction

	function automatic gate_tick_t mk_tick(input logic btn, input logic [9:0] ir,
		input logic card, input logic [31:0] uid, input logic four);
		gate_tick_t t;
		t.button = btn;
		t.ir = ir;
		t.card = card;
		t.uid = uid;
		t.four = four;
		return t;
	endfunction

	function automatic logic [9:0] ir_high();
		return 10'($urandom_range(1023, int'(cfg_now.ir_thr)));
	endfunction

	function automatic logic [9:0] ir_low();
		return (cfg_now.ir_thr == 0) ? 10'd0 : 10'($urandom_range(int'(cfg_now.ir_thr) - 1, 0));
	endfunction

	function automatic gate_tick_t quiet_tick(input logic [9:0] ir);
		return mk_tick(1'b1, ir, 1'b0, $urandom, 1'($urandom_range(1, 0)));
	endfunction

	function automatic gate_tick_t random_tick();
		logic [31:0] uid;
		uid = ($urandom_range(1, 0) == 0) ? $urandom : BADGE_UID[$urandom_range(7, 0)];
		return mk_tick(1'($urandom_range(1, 0)), 10'($urandom_range(1023, 0)),
			$urandom_range(3, 0) == 0, uid, $urandom_range(4, 0) != 0);
	endfunction

	// One visit: card, wait for the prompt, press, walk through, let the screen time out
	task automatic queue_session();
		int span;
		int pick;
		logic [31:0] who;
		span = cfg_now.prompt;
		if (cfg_now.arm > span)
			span = cfg_now.arm;
		if (cfg_now.hold > span)
			span = cfg_now.hold;
		if (span > 12)
			span = 12;
		span += 2;
		pick = $urandom_range(9, 0);
		who = BADGE_UID[$urandom_range(6, 0)];
		if (pick < 7)
			pending_ticks.push_back(mk_tick(1'b1, ir_high(), 1'b1, who, 1'b1));
		else if (pick == 7)
			pending_ticks.push_back(mk_tick(1'b1, ir_high(), 1'b1, $urandom, 1'b1));
		else if (pick == 8)
			pending_ticks.push_back(mk_tick(1'b1, ir_high(), 1'b1, who, 1'b0));
		repeat ($urandom_range(span, 0))
			pending_ticks.push_back(quiet_tick(ir_high()));
		repeat ($urandom_range(3, 1))
			pending_ticks.push_back(mk_tick(1'b0, ir_high(), 1'b0, $urandom, 1'b1));
		repeat ($urandom_range(span, 0))
			pending_ticks.push_back(quiet_tick(ir_high()));
		repeat ($urandom_range(3, 1))
			pending_ticks.push_back(quiet_tick(ir_low()));
		repeat ($urandom_range(span, 0))
			pending_ticks.push_back(quiet_tick(10'($urandom_range(1023, 0))));
		if ($urandom_range(3, 0) == 0)
			repeat ($urandom_range(3, 1))
				pending_ticks.push_back(random_tick());
	endtask

	task automatic fill_random(input int n);
		int issued;
		int depth0;
		issued = 0;
		while (issued < n) begin
			depth0 = pending_ticks.size();
			queue_session();
			issued += pending_ticks.size() - depth0;
		end
	endtask

	// Wait until every tick is in and every result is out, then let the pipe empty
	task automatic settle();
		while (pending_ticks.size() != 0 || tick_bus.valid || gate_outputs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [agc_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		case (idx)
			agc_pkg::REG_PROMPT_DELAY: cfg_now.prompt = val;
			agc_pkg::REG_PASS_ARM:     cfg_now.arm = val;
			agc_pkg::REG_MESSAGE_HOLD: cfg_now.hold = val;
			agc_pkg::REG_IR_THRESHOLD: cfg_now.ir_thr = val[9:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [15:0] prompt, input logic [15:0] arm,
		input logic [15:0] hold, input logic [15:0] thr);
		write_reg(agc_pkg::REG_PROMPT_DELAY, prompt);
		write_reg(agc_pkg::REG_PASS_ARM, arm);
		write_reg(agc_pkg::REG_MESSAGE_HOLD, hold);
		write_reg(agc_pkg::REG_IR_THRESHOLD, thr);
	endtask

	// Tick driver: predict on each accepted beat, then present the next one
	always @(posedge clk) begin : drive_ticks
		gate_tick_t nxt;
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (tick_bus.valid && tick_bus.ready)
				gate_outputs_due.push_back(advance_gate(on_wire));
			if (!tick_bus.valid || tick_bus.ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					tick_bus.valid <= 1'b0;
				end else if (bursts_on && $urandom_range(7, 0) == 0) begin
					src_gap <= $urandom_range(16, 0);
					tick_bus.valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					nxt = pending_ticks.pop_front();
					on_wire <= nxt;
					tick_bus.valid <= 1'b1;
					tick_bus.button_level <= nxt.button;
					tick_bus.ir_sample <= nxt.ir;
					tick_bus.card_present <= nxt.card;
					tick_bus.card_uid <= nxt.uid;
					tick_bus.uid_is_four_bytes <= nxt.four;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and sink stalls
	always @(posedge clk) begin : watch_results
		agc_pkg::result_t got;
		agc_pkg::result_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				got.screen = result_bus.screen;
				got.buzzer = result_bus.buzzer;
				got.access_log = result_bus.access_log;
				got.logged_member_id = result_bus.logged_member_id;
				got.gate_opened_event = result_bus.gate_opened_event;
				got.entry_completed_event = result_bus.entry_completed_event;
				got.session_member_id = result_bus.session_member_id;
				if (gate_outputs_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing due: %s", $realtime, show(got));
				end else begin
					want = gate_outputs_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch\n  expected %s\n  actual   %s",
								$realtime, show(want), show(got));
					end
				end
			end
			if (snk_gap != 0) begin
				snk_gap <= snk_gap - 1;
				result_bus.ready <= 1'b0;
			end else if (bursts_on && $urandom_range(7, 0) == 0) begin
				snk_gap <= $urandom_range(16, 0);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : run
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.button_level = 1'b1;
		tick_bus.ir_sample = '0;
		tick_bus.card_present = 1'b0;
		tick_bus.card_uid = '0;
		tick_bus.uid_is_four_bytes = 1'b0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		on_wire = '0;

		cfg_now.prompt = agc_pkg::RST_PROMPT_DELAY;
		cfg_now.arm = agc_pkg::RST_PASS_ARM;
		cfg_now.hold = agc_pkg::RST_MESSAGE_HOLD;
		cfg_now.ir_thr = agc_pkg::RST_IR_THRESHOLD;
		btn_prev = 1'b1;
		granted_now = 1'b0;
		entry_done = 1'b0;
		gate_is_open = 1'b0;
		prompt_due = 1'b0;
		status_up = 1'b0;
		open_age = '0;
		grant_age = '0;
		status_age = '0;
		session_badge = agc_pkg::ID_NONE;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: only card and button decisions show up here
		fill_random(40);
		settle();

		// Directed: short delays so every screen is reached within a few ticks
		set_timing(16'd2, 16'd3, 16'd5, 16'd450);
		write_reg(REG_TOP, 16'hFFFF);
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, 32'h0, 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[0], 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[3], 1'b1));
		pending_ticks.push_back(mk_tick(1'b0, 10'd1023, 1'b1, 32'hFFFFFFFF, 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b0, 32'h0, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[4], 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b0, 32'hFFFFFFFF, 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b0, 32'h0, 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 10'd0, 1'b0, 32'h0, 1'b0));
		repeat (3)
			pending_ticks.push_back(mk_tick(1'b1, 10'd0, 1'b0, 32'h0, 1'b0));
		repeat (5)
			pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b0, 32'h0, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[6], 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[1], 1'b0));
		pending_ticks.push_back(mk_tick(1'b0, 10'd1023, 1'b0, 32'h0, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[2], 1'b1));
		pending_ticks.push_back(mk_tick(1'b0, 10'd1023, 1'b0, 32'h0, 1'b0));
		pending_ticks.push_back(mk_tick(1'b1, 10'd1023, 1'b1, BADGE_UID[5], 1'b1));
		pending_ticks.push_back(mk_tick(1'b1, 10'd0, 1'b0, 32'h0, 1'b0));
		settle();

		set_timing(16'd3, 16'd4, 16'd6, 16'd450);
		write_reg(REG_SPARE, 16'd0);
		fill_random(250);
		settle();

		// Zero delays for every timer; threshold at its top
		set_timing(16'd0, 16'd0, 16'd0, 16'hFFFF);
		fill_random(150);
		settle();

		// Threshold zero: no sample counts as a pass
		set_timing(16'($urandom_range(8, 0)), 16'($urandom_range(8, 0)),
			16'($urandom_range(12, 0)), 16'd0);
		fill_random(150);
		settle();

		// Long wait: open the gate, stay quiet well past every delay, then pass
		bursts_on = 1'b0;
		set_timing(16'd40, 16'd60, 16'd80, 16'd512);
		pending_ticks.push_back(mk_tick(1'b1, ir_high(), 1'b1, BADGE_UID[0], 1'b1));
		pending_ticks.push_back(mk_tick(1'b0, ir_high(), 1'b0, $urandom, 1'b1));
		repeat (100)
			pending_ticks.push_back(quiet_tick(ir_high()));
		repeat (2)
			pending_ticks.push_back(quiet_tick(ir_low()));
		settle();

		bursts_on = 1'b1;
		set_timing(16'($urandom_range(10, 0)), 16'($urandom_range(10, 0)),
			16'($urandom_range(14, 0)), 16'($urandom_range(1023, 1)));
		fill_random(250);
		settle();
		bursts_on = 1'b0;
		fill_random(150);
		settle();

		if (mismatches == 0 && gate_outputs_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
